>>> sv/vfv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_pkg
// Shared constants for the voxel face visibility store: grid geometry,
// occupancy row layout, operation codes and sequencer step counts.
// ----------------------------------------------------------------------------
package vfv_pkg;

    // Side of the cubic grid. Coordinates are six bits wide, so only the first
    // 64 positions of each axis can ever be addressed.
    localparam int GRID_SIDE = 64;
    localparam int COORD_W   = 6;
    localparam int EFF_SIDE  = (GRID_SIDE > 64) ? 64 : GRID_SIDE;

    // The occupancy store holds one row per (x, y) pair, one bit per z.
    localparam int AXIS_W = (EFF_SIDE > 1) ? $clog2(EFF_SIDE) : 1;
    localparam int ROW_W  = 1 << AXIS_W;
    localparam int ROW_AW = 2 * AXIS_W;

    localparam logic [COORD_W-1:0] TOP_COORD  = COORD_W'(EFF_SIDE - 1);
    localparam logic [COORD_W:0]   SIDE_LIMIT = (COORD_W + 1)'(EFF_SIDE);

    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int             STEP_W          = 3;
    localparam logic [STEP_W-1:0] LAST_MARK_STEP  = 3'd1;
    localparam logic [STEP_W-1:0] LAST_QUERY_STEP = 3'd5;

endpackage

>>> sv/vfv_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_item_if
// Request channel carrying one mark or query request with its coordinates.
// ----------------------------------------------------------------------------
interface vfv_item_if;

    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [vfv_pkg::COORD_W-1:0] x_coord;
    logic [vfv_pkg::COORD_W-1:0] y_coord;
    logic [vfv_pkg::COORD_W-1:0] z_coord;

    modport source (output valid, output op, output x_coord, output y_coord,
                    output z_coord, input ready);
    modport sink (input valid, input op, input x_coord, input y_coord,
                  input z_coord, output ready);

endinterface

>>> sv/vfv_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_result_if
// Result channel carrying the face mask, occupancy and bounding box.
// ----------------------------------------------------------------------------
interface vfv_result_if;

    logic                        valid;
    logic                        ready;
    logic [5:0]                  face_mask;
    logic                        occupied;
    logic [vfv_pkg::COORD_W-1:0] min_x;
    logic [vfv_pkg::COORD_W-1:0] max_x;
    logic [vfv_pkg::COORD_W-1:0] min_y;
    logic [vfv_pkg::COORD_W-1:0] max_y;
    logic [vfv_pkg::COORD_W-1:0] min_z;
    logic [vfv_pkg::COORD_W-1:0] max_z;

    modport source (output valid, output face_mask, output occupied,
                    output min_x, output max_x, output min_y, output max_y,
                    output min_z, output max_z, input ready);
    modport sink (input valid, input face_mask, input occupied,
                  input min_x, input max_x, input min_y, input max_y,
                  input min_z, input max_z, output ready);

endinterface

>>> sv/voxel_face_visibility_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_visibility_store_core
// Occupancy grid with running bounding box; answers face visibility queries.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  item      sink       op, x_coord, y_coord, z_coord
//  result    source     face_mask, occupied, min/max of x, y and z
//
//  A query or a mark reaches the output register when its last step commits:
//  the single read port of the occupancy store delivers one row per cycle,
//  and a query needs five rows. The block is ready again in the cycle after
//  the result is committed, and takes no new request before that.
//  After reset a clearing pass writes 2**ROW_AW rows (4096 for a 64 side)
//  before the first request is taken.
//  A finished result waits in the output register; a new request may be
//  taken meanwhile, and it stalls in its last step until that slot is free.
// ----------------------------------------------------------------------------
module voxel_face_visibility_store_core (
    input logic         clk,
    input logic         rst_n,
    vfv_item_if.sink    item,
    vfv_result_if.source result
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    localparam int CW = vfv_pkg::COORD_W;
    localparam int SW = vfv_pkg::STEP_W;
    localparam int AW = vfv_pkg::AXIS_W;
    localparam int RW = vfv_pkg::ROW_W;
    localparam int RAW = vfv_pkg::ROW_AW;

    logic [1:0]    state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic [RAW-1:0] clr_cnt_reg, clr_cnt_next;

    logic          op_reg;
    logic [CW-1:0] x_reg, y_reg, z_reg;
    logic          nb_ok_reg;
    logic [5:0]    mask_reg, mask_next;
    logic          occ_reg, occ_next;

    logic [CW-1:0] lo_x_reg, lo_y_reg, lo_z_reg, hi_x_reg, hi_y_reg, hi_z_reg;
    logic [CW-1:0] lo_x_next, lo_y_next, lo_z_next, hi_x_next, hi_y_next, hi_z_next;

    logic          out_valid_reg, out_valid_next;
    logic [5:0]    out_mask_reg;
    logic          out_occ_reg;
    logic [CW-1:0] out_lo_x_reg, out_lo_y_reg, out_lo_z_reg;
    logic [CW-1:0] out_hi_x_reg, out_hi_y_reg, out_hi_z_reg;

    logic [RW-1:0] mem [2**RAW];
    logic [RW-1:0] rd_data_reg;
    logic          rd_en, wr_en;
    logic [RAW-1:0] rd_addr, wr_addr;
    logic [RW-1:0] wr_data;

    logic          accept, last_step, out_free, commit, mark_in;
    logic          sel_y;
    logic [CW:0]   delta, adj;
    logic [CW-1:0] nb_x, nb_y, other;
    logic          nb_ok;
    logic          z_in, center_fill, zm_fill, zp_fill;
    logic [CW:0]   zm, zp;

    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign last_step = (op_reg == vfv_pkg::OP_MARK) ? (step_reg == vfv_pkg::LAST_MARK_STEP)
                                                    : (step_reg == vfv_pkg::LAST_QUERY_STEP);
    assign commit   = (state_reg == ST_RUN) && last_step && out_free;

    // Shared neighbour unit: one axis is moved by one step or left as it is, the other is kept.
    always_comb
    begin
        sel_y = 1'b0;
        delta = '0;
        case (step_reg)
            3'd0:
            begin
                sel_y = 1'b0;
                delta = '0;
            end
            3'd1:
            begin
                sel_y = 1'b0;
                delta = '1;
            end
            3'd2:
            begin
                sel_y = 1'b0;
                delta = (CW + 1)'(1);
            end
            3'd3:
            begin
                sel_y = 1'b1;
                delta = (CW + 1)'(1);
            end
            3'd4:
            begin
                sel_y = 1'b1;
                delta = '1;
            end
            default:
            begin
                sel_y = 1'b0;
                delta = '0;
            end
        endcase
    end

    assign adj   = {1'b0, (sel_y ? y_reg : x_reg)} + delta;
    assign other = sel_y ? x_reg : y_reg;
    assign nb_x  = sel_y ? x_reg : adj[CW-1:0];
    assign nb_y  = sel_y ? adj[CW-1:0] : y_reg;
    // A step below zero wraps to the top of the seven-bit range and fails too.
    assign nb_ok = (adj < vfv_pkg::SIDE_LIMIT) && ({1'b0, other} < vfv_pkg::SIDE_LIMIT);

    assign rd_addr = {nb_x[AW-1:0], nb_y[AW-1:0]};
    assign rd_en   = (state_reg == ST_RUN) && !last_step;

    // Bits of the row that has just come back from the store.
    assign z_in = {1'b0, z_reg} < vfv_pkg::SIDE_LIMIT;
    assign zm   = {1'b0, z_reg} - (CW + 1)'(1);
    assign zp   = {1'b0, z_reg} + (CW + 1)'(1);
    assign center_fill = nb_ok_reg && z_in && rd_data_reg[z_reg[AW-1:0]];
    assign zm_fill = nb_ok_reg && (zm < vfv_pkg::SIDE_LIMIT) && rd_data_reg[zm[AW-1:0]];
    assign zp_fill = nb_ok_reg && (zp < vfv_pkg::SIDE_LIMIT) && rd_data_reg[zp[AW-1:0]];

    assign mark_in = nb_ok_reg && z_in;

    always_comb
    begin
        mask_next = mask_reg;
        occ_next  = occ_reg;
        if (step_reg == 3'd1)
        begin
            occ_next     = center_fill;
            mask_next[0] = !zm_fill;
            mask_next[1] = !zp_fill;
        end
        else if (step_reg != 3'd0)
        begin
            mask_next[step_reg] = !center_fill;
        end
    end

    always_comb
    begin
        lo_x_next = lo_x_reg;
        lo_y_next = lo_y_reg;
        lo_z_next = lo_z_reg;
        hi_x_next = hi_x_reg;
        hi_y_next = hi_y_reg;
        hi_z_next = hi_z_reg;
        if (op_reg == vfv_pkg::OP_MARK && mark_in)
        begin
            if (x_reg < lo_x_reg) lo_x_next = x_reg;
            if (y_reg < lo_y_reg) lo_y_next = y_reg;
            if (z_reg < lo_z_reg) lo_z_next = z_reg;
            if (x_reg > hi_x_reg) hi_x_next = x_reg;
            if (y_reg > hi_y_reg) hi_y_next = y_reg;
            if (z_reg > hi_z_reg) hi_z_next = z_reg;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {x_reg[AW-1:0], y_reg[AW-1:0]};
        wr_data = rd_data_reg | (RW'(1) << z_reg[AW-1:0]);
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else if (commit && op_reg == vfv_pkg::OP_MARK && mark_in)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + RAW'(1);
                if (clr_cnt_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (!last_step)
                    step_next = step_reg + SW'(1);
                else if (commit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            lo_x_reg      <= vfv_pkg::TOP_COORD;
            lo_y_reg      <= vfv_pkg::TOP_COORD;
            lo_z_reg      <= vfv_pkg::TOP_COORD;
            hi_x_reg      <= '0;
            hi_y_reg      <= '0;
            hi_z_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                lo_x_reg <= lo_x_next;
                lo_y_reg <= lo_y_next;
                lo_z_reg <= lo_z_next;
                hi_x_reg <= hi_x_next;
                hi_y_reg <= hi_y_next;
                hi_z_reg <= hi_z_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= item.op;
            x_reg  <= item.x_coord;
            y_reg  <= item.y_coord;
            z_reg  <= item.z_coord;
        end
        if (rd_en)
            nb_ok_reg <= nb_ok;
        if (state_reg == ST_RUN && !last_step)
        begin
            mask_reg <= mask_next;
            occ_reg  <= occ_next;
        end
        if (commit)
        begin
            if (op_reg == vfv_pkg::OP_MARK)
            begin
                out_mask_reg <= '0;
                out_occ_reg  <= 1'b0;
            end
            else
            begin
                out_mask_reg <= mask_next;
                out_occ_reg  <= occ_next;
            end
            out_lo_x_reg <= lo_x_next;
            out_lo_y_reg <= lo_y_next;
            out_lo_z_reg <= lo_z_next;
            out_hi_x_reg <= hi_x_next;
            out_hi_y_reg <= hi_y_next;
            out_hi_z_reg <= hi_z_next;
        end
    end

    // Occupancy store: one row per (x, y), one write and one read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign item.ready       = (state_reg == ST_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.face_mask = out_mask_reg;
    assign result.occupied  = out_occ_reg;
    assign result.min_x     = out_lo_x_reg;
    assign result.max_x     = out_hi_x_reg;
    assign result.min_y     = out_lo_y_reg;
    assign result.max_y     = out_hi_y_reg;
    assign result.min_z     = out_lo_z_reg;
    assign result.max_z     = out_hi_z_reg;

`ifndef SYNTHESIS
    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN && step_reg == '0))
        else $error("accepted request did not start the sequencer");

    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !wr_en)
        else $error("occupancy store written while idle");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= vfv_pkg::LAST_QUERY_STEP))
        else $error("sequencer step out of range");

    a_commit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("finished request did not reach the output register");
`endif

endmodule
